[rtl/lirs_pkg.sv]
// Shared constants and controller/datapath interface types for the resampler core.
package lirs_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 22;

   // Default number of fraction bits in the read position
   localparam int FRAC_BITS_DEF = 16;

   // Largest number of results one request can cause
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture the incoming request
      logic keep;       // store current sample as previous, mark it valid
      logic emit;       // write one result into the output register
      logic hold_mode;  // results repeat the current sample
      logic adjust;     // interpolation run done: step position into next interval
      logic clear;      // end of stream: drop history
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic have_prev;  // a previous sample is stored
      logic last;       // captured request ends the stream
      logic can_emit;   // position is inside the interval and budget remains
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

[rtl/linear_interp_resampler_core.sv]
// Top level of the linear-interpolation sample-rate converter.
// Streaming resampler: each request carries one signed 16-bit sample and an end-of-stream
// flag; results are linearly interpolated samples at read positions that advance by
// csr_step_q16 (source rate over destination rate, unsigned fixed point with FRAC_BITS
// fraction bits, clamped below at 1/32). The first sample of a stream gives no result unless
// it is also the final sample; the final sample is repeated for positions at or past it. A
// request is taken, then the single interpolator writes one result per cycle into the output
// register while the output side does not stall, and each run (interpolation, and on the final
// sample the hold run) then closes with a step that writes no result. The output register
// lets the next request be taken while the last result of the previous one still waits.
// Write csr_step_q16 only while the block is idle.
module linear_interp_resampler_core #(
   parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lirs_pkg::STEP_W-1:0]          csr_step_q16,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_run_last,
   output logic                                 rsp_stream_end
);

   lirs_pkg::cmd_type    cmd;
   lirs_pkg::status_type status;

   // Sequencer
   lirs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .status          (status),
      .cmd             (cmd)
   );

   // Position, history and interpolation
   lirs_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_step_q16    (csr_step_q16),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_end  (rsp_stream_end),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

[rtl/lirs_ctrl.sv]
// Controller state machine: sequences capture, interpolation run, hold run and commit.
module lirs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_sample,
   output logic                 req_stall,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LERP = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Requests are taken only between runs
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.have_prev) begin
                  state_in = ST_LERP;
               end else if (req_last_sample) begin
                  state_in = ST_HOLD;
               end else begin
                  // first sample of a stream: just remember it
                  cmd.keep = 1'b1;
               end
            end
         end
         ST_LERP: begin
            if (status.can_emit) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.adjust = 1'b1;
               if (status.last) begin
                  state_in = ST_HOLD;
               end else begin
                  cmd.keep = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            cmd.hold_mode = 1'b1;
            if (status.can_emit) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/lirs_datapath.sv]
// Datapath: step register, history, read position, interpolator and output register.
module lirs_datapath #(
   parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lirs_pkg::STEP_W-1:0]         csr_step_q16,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_run_last,
   output logic                                rsp_stream_end,
   input  lirs_pkg::cmd_type                   cmd,
   output lirs_pkg::status_type                status
);

   localparam int SW = lirs_pkg::SAMPLE_W;
   localparam int STW = lirs_pkg::STEP_W;
   localparam int CW = lirs_pkg::CNT_W;
   // position must hold (interval) + (largest step) without wrapping
   localparam int REL_W = ((FRAC_BITS + 1 > STW) ? FRAC_BITS + 1 : STW) + 1;
   localparam int NUM_W = FRAC_BITS + SW + 3;

   localparam logic [REL_W-1:0] ONE_REL    = REL_W'(1) << FRAC_BITS;
   localparam logic [REL_W-1:0] TWO_REL    = REL_W'(1) << (FRAC_BITS + 1);
   localparam logic [STW-1:0]   MIN_STEP   = STW'(1) << (FRAC_BITS - 5);
   localparam logic [STW-1:0]   STEP_RESET = STW'(1) << FRAC_BITS;
   localparam logic [NUM_W-1:0] RND_BIAS   = (NUM_W'(1) << FRAC_BITS) - NUM_W'(1);
   localparam logic [CW-1:0]    CNT_MAX    = CW'(lirs_pkg::MAX_RESULTS);

   logic [STW-1:0]          step_ff;
   logic [STW-1:0]          step_in;
   logic signed [SW-1:0]    prev_ff;
   logic signed [SW-1:0]    prev_in;
   logic                    have_prev_ff;
   logic                    have_prev_in;
   logic [REL_W-1:0]        rel_ff;
   logic [REL_W-1:0]        rel_in;
   logic signed [SW-1:0]    cur_ff;
   logic signed [SW-1:0]    cur_in;
   logic                    last_ff;
   logic                    last_in;
   logic [CW-1:0]           cnt_ff;
   logic [CW-1:0]           cnt_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [SW-1:0]    rsp_sample_ff;
   logic signed [SW-1:0]    rsp_sample_in;
   logic                    rsp_run_last_ff;
   logic                    rsp_run_last_in;
   logic                    rsp_stream_end_ff;
   logic                    rsp_stream_end_in;

   logic [STW-1:0]          step_eff;
   logic [REL_W-1:0]        rel_nx;
   logic [CW-1:0]           cnt_nx;
   logic                    more;
   logic signed [SW:0]      diff;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [FRAC_BITS+SW+1:0] prod;
   logic [NUM_W-1:0]        num;
   logic [NUM_W-1:0]        rnd;
   logic signed [SW-1:0]    lerp_q;

   // Effective step, clamped from below
   assign step_eff = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   assign rel_nx   = rel_ff + REL_W'(step_eff);
   assign cnt_nx   = cnt_ff + CW'(1);

   // Interpolation: (ONE*a + f*(b-a)) / ONE, truncated toward zero
   assign diff   = {cur_ff[SW-1], cur_ff} - {prev_ff[SW-1], prev_ff};
   assign frac_s = {1'b0, rel_ff[FRAC_BITS-1:0]};
   assign prod   = frac_s * diff;
   assign num    = {{3{prev_ff[SW-1]}}, prev_ff, {FRAC_BITS{1'b0}}}
                 + {prod[FRAC_BITS+SW+1], prod};
   assign rnd    = num + (num[NUM_W-1] ? RND_BIAS : '0);
   assign lerp_q = rnd[FRAC_BITS +: SW];

   // Does another result follow the one being written now
   always_comb begin
      more = (cnt_nx < CNT_MAX)
           && ((rel_nx < ONE_REL) || (!cmd.hold_mode && last_ff && (rel_nx < TWO_REL)));
   end

   // Status to controller
   assign status.have_prev = have_prev_ff;
   assign status.last      = last_ff;
   assign status.can_emit  = (rel_ff < ONE_REL) && (cnt_ff < CNT_MAX);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Next-state logic
   always_comb begin
      step_in           = step_ff;
      prev_in           = prev_ff;
      have_prev_in      = have_prev_ff;
      rel_in            = rel_ff;
      cur_in            = cur_ff;
      last_in           = last_ff;
      cnt_in            = cnt_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_in     = rsp_sample_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_stream_end_in = rsp_stream_end_ff;

      if (csr_wr_en) begin
         step_in = csr_step_q16;
      end

      // capture request
      if (cmd.load) begin
         cur_in  = req_sample;
         last_in = req_last_sample;
         cnt_in  = '0;
      end

      // output register
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_sample_in     = cmd.hold_mode ? cur_ff : lerp_q;
         rsp_run_last_in   = !more;
         rsp_stream_end_in = last_ff && !more;
         rel_in            = rel_nx;
         cnt_in            = cnt_nx;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // move position into the next source interval
      if (cmd.adjust) begin
         rel_in = (rel_ff >= ONE_REL) ? rel_ff - ONE_REL : '0;
      end

      // history update
      if (cmd.keep) begin
         prev_in      = cmd.load ? req_sample : cur_ff;
         have_prev_in = 1'b1;
      end
      if (cmd.clear) begin
         prev_in      = '0;
         have_prev_in = 1'b0;
         rel_in       = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         rel_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         rel_ff       <= rel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff            <= cur_in;
      last_ff           <= last_in;
      rsp_sample_ff     <= rsp_sample_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_stream_end_ff <= rsp_stream_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_stream_end = rsp_stream_end_ff;

`ifndef SYNTHESIS
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a waiting result");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("result count past limit");
   a_lerp_has_prev: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.hold_mode) |-> have_prev_ff)
      else $error("interpolated result without a previous sample");
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stream_end_ff) |-> rsp_run_last_ff)
      else $error("stream end not on last result of request");
   a_emit_in_interval: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> ($past(rel_ff) < ONE_REL))
      else $error("result written outside the source interval");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the linear-interpolation resampler core.
`timescale 1ns / 100ps

module tb;

   localparam int STEP_W   = lirs_pkg::STEP_W;
   localparam int SAMPLE_W = lirs_pkg::SAMPLE_W;

   // Q7.16 position constants
   localparam longint unsigned ONE_POS  = 64'd1 << lirs_pkg::FRAC_BITS_DEF;
   localparam longint unsigned MIN_STEP = ONE_POS >> 5;
   localparam longint unsigned REL_MASK = (64'd1 << 23) - 1;

   localparam logic [STEP_W-1:0] STEP_UNITY = STEP_W'(ONE_POS);
   localparam logic [STEP_W-1:0] STEP_FLOOR = STEP_W'(MIN_STEP);
   localparam logic [STEP_W-1:0] STEP_ALL1  = '1;

   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 100;  // covers a full 64-result request plus close
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       run_last;
      logic                       stream_end;
   } out_item_t;

   // Expected-output tracker: predicts resampled outputs per request and checks them
   class resampler_scoreboard;
      out_item_t                  pending_outputs[$];
      logic [STEP_W-1:0]          step_reg;
      logic signed [SAMPLE_W-1:0] prev_sample;
      bit                         have_prev;
      longint unsigned            rel_pos;
      int                         requests;
      int                         streams;
      int                         results_seen;
      int                         errors;

      function new();
         step_reg     = STEP_UNITY;
         prev_sample  = '0;
         have_prev    = 1'b0;
         rel_pos      = 0;
         requests     = 0;
         streams      = 0;
         results_seen = 0;
         errors       = 0;
      endfunction

      function void set_step(logic [STEP_W-1:0] value);
         step_reg = value;
      endfunction

      function int outstanding();
         return pending_outputs.size();
      endfunction

      // Work out every output one accepted request causes
      function void take_request(logic signed [SAMPLE_W-1:0] cur, logic last);
         longint unsigned incr;
         longint unsigned pos;
         longint          numer;
         out_item_t       item;
         out_item_t       run[$];
         incr = (step_reg < MIN_STEP) ? MIN_STEP : longint'(step_reg);
         pos  = rel_pos;
         requests++;
         item = '0;
         // interpolate between previous and current sample
         if (have_prev) begin
            while (pos < ONE_POS && run.size() < lirs_pkg::MAX_RESULTS) begin
               numer = longint'(ONE_POS - pos) * longint'(prev_sample)
                     + longint'(pos) * longint'(cur);
               item.sample_out = SAMPLE_W'(numer / longint'(ONE_POS));
               run.push_back(item);
               pos += incr;
            end
            pos = (pos >= ONE_POS) ? pos - ONE_POS : 0;
         end
         // end of stream: hold the final sample, then drop history
         if (last) begin
            while (pos < ONE_POS && run.size() < lirs_pkg::MAX_RESULTS) begin
               item.sample_out = cur;
               run.push_back(item);
               pos += incr;
            end
            have_prev   = 1'b0;
            rel_pos     = 0;
            prev_sample = '0;
            streams++;
         end else begin
            have_prev   = 1'b1;
            prev_sample = cur;
            rel_pos     = pos & REL_MASK;
         end
         if (run.size() > 0) begin
            run[run.size()-1].run_last   = 1'b1;
            run[run.size()-1].stream_end = last;
         end
         foreach (run[i]) pending_outputs.push_back(run[i]);
      endfunction

      // Compare one accepted output with the oldest prediction
      function void check_result(logic signed [SAMPLE_W-1:0] s, logic rl, logic se);
         out_item_t got;
         out_item_t want;
         got = '{s, rl, se};
         results_seen++;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output sample_out=%0d run_last=%0b stream_end=%0b",
                     $time, s, rl, se);
            errors++;
            return;
         end
         want = pending_outputs.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected sample_out=%0d run_last=%0b stream_end=%0b",
                     $time, want.sample_out, want.run_last, want.stream_end);
            $display("%0t:          actual   sample_out=%0d run_last=%0b stream_end=%0b",
                     $time, s, rl, se);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [STEP_W-1:0]          csr_step_q16 = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last_sample = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_run_last;
   logic                       rsp_stream_end;

   resampler_scoreboard board;
   int  burst_left = 0;
   bit  no_gaps = 1'b0;
   bit  long_hold_pending = 1'b0;
   int  settings_used = 0;

   linear_interp_resampler_core DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_step_q16    (csr_step_q16),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_end  (rsp_stream_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Output monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_sample_out, rsp_run_last, rsp_stream_end);
   end

   // Receiver stall patterns, with a single long hold-off during the first random phase
   initial begin : rsp_pacing
      int mode;
      int span;
      int n;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (n = 0; n < span && !long_hold_pending; n++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((n % 3) == 0);
            endcase
            @(posedge clock);
         end
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_pending = 1'b0;
         end
      end
   end

   // Present one request, with a random gap at the start of each burst unless no_gaps is set
   task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= l;
      do @(posedge clock); while (req_stall);
      board.take_request(s, l);
   endtask

   // Step register write, only once the block has drained
   task automatic write_step(input logic [STEP_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_step_q16 <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_step(value);
      settings_used++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return SAMPLE_W'($urandom_range(0, 255)) - 16'sd128;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: return STEP_W'($urandom_range(0, 2047));
         1: return STEP_W'($urandom_range(2048, 16384));
         2, 3: return STEP_UNITY;
         4, 5: return STEP_W'($urandom_range(16384, 131072));
         6: return STEP_W'($urandom_range(131072, 2097152));
         7: return STEP_W'($urandom_range(2097152, 4194303));
         8: return ($urandom_range(0, 1) == 0) ? STEP_FLOOR : STEP_ALL1;
         default: return STEP_W'($urandom_range(40000, 90000));
      endcase
   endfunction

   // Main sequence
   initial begin : stimulus
      int               random_items;
      int               phase_len;
      int               stream_left;
      int               k;
      bit               first_phase;
      logic [STEP_W-1:0] stp;
      board        = new();
      random_items = 0;
      stream_left  = 0;
      first_phase  = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: plain copy at unity step with sample extremes
      write_step(STEP_UNITY);
      offer(16'sh7fff, 1'b0);
      offer(16'sh8000, 1'b0);
      offer(16'sd0, 1'b0);
      offer(-16'sd1, 1'b0);
      offer(16'sd1, 1'b1);
      // a stream of one sample
      offer(16'sh8000, 1'b1);
      // finest step: most outputs per request
      write_step(STEP_FLOOR);
      offer(16'sh7fff, 1'b0);
      offer(16'sh8000, 1'b1);
      // zero step is clamped to the floor
      write_step('0);
      offer(16'sd100, 1'b0);
      offer(-16'sd100, 1'b1);
      // all-ones step: most requests silent, final one too
      write_step(STEP_ALL1);
      offer(16'sd1000, 1'b0);
      offer(16'sd2000, 1'b0);
      offer(16'sd3000, 1'b0);
      offer(16'sd4000, 1'b0);
      offer(16'sd5000, 1'b1);
      write_step(STEP_W'(2097152));
      offer(-16'sd7, 1'b0);
      offer(16'sd7, 1'b0);
      offer(16'sd9, 1'b1);
      // 1.5 step with alternating extremes
      write_step(STEP_W'(98304));
      offer(16'sh8000, 1'b0);
      offer(16'sh7fff, 1'b0);
      offer(16'sh8000, 1'b0);
      offer(16'sh7fff, 1'b1);

      // Random phases; the first one runs against a long receiver hold-off
      while (random_items < RANDOM_ITEMS) begin
         stp = first_phase ? STEP_W'(32768) : pick_step();
         write_step(stp);
         phase_len = (stp < 16384) ? 12 : $urandom_range(25, 50);
         no_gaps = first_phase || ($urandom_range(0, 3) == 0);
         if (first_phase)
            long_hold_pending = 1'b1;
         first_phase = 1'b0;
         for (k = 0; k < phase_len; k++) begin
            if (stream_left == 0)
               stream_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
            stream_left--;
            offer(random_sample(), stream_left == 0);
            random_items++;
         end
      end
      if (stream_left != 0)
         offer(random_sample(), 1'b1);

      // Drain
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests in %0d completed streams across %0d step settings,",
               board.requests, board.streams, settings_used);
      $display("with %0d outputs checked, including a long output hold-off.",
               board.results_seen);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #80_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
